// ----- rtl/nsp_pkg.sv -----
// Shared types, character codes and helpers for the NMEA sentence parser.
// No dependencies; used by nsp_update and nmea_sentence_parser.
package nsp_pkg;

    // Field counter and character counter widths (fit the parameter ranges)
    localparam int unsigned FC_W = 6;
    localparam int unsigned CC_W = 8;
    localparam int unsigned OUT_W = 32;

    // Framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Sentence scanner state
    typedef struct packed {
        logic            valid_flag;
        logic [FC_W-1:0] field_counter;
        logic [CC_W-1:0] char_count;
        logic [7:0]      xor_sum;
        logic            after_star;
        logic [7:0]      received_sum;
        logic            received_overflow;
        logic            hex_ended;
    } state_t;

    // One result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       too_long;
        logic [7:0] running_checksum;
        logic [4:0] field_count;
        logic       sentence_valid;
        logic       field_closed;
        logic       is_content;
        logic [4:0] field_number;
        logic [7:0] out_byte;
    } result_t;

    // Hex digit decode: is_hex flags a digit in either case
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.is_hex = 1'b1;
            h.value  = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            h.is_hex = 1'b1;
            h.value  = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    // Count of closed fields from fields opened, capped at 31
    function automatic logic [4:0] fields_less_one(input logic [FC_W-1:0] fc);
        logic [FC_W-1:0] t;
        t = (fc == '0) ? '0 : fc - FC_W'(1);
        return t[FC_W-1] ? 5'd31 : t[4:0];
    endfunction

endpackage

// ----- rtl/nmea_sentence_parser.sv -----
// NMEA 0183 sentence parser: tags each received character with its field.
// A result word is registered and presented in the cycle after its character is accepted.
// Throughput: one character per cycle; the single output register refills on the
// same edge it is taken, so only a stalled consumer holds off the input.
// Reset (rst_n low, asynchronous): scanner state cleared, no result pending.
// Depends on nsp_pkg and nsp_update.
module nmea_sentence_parser #(
    parameter int unsigned MAX_LEN    = 128,
    parameter int unsigned MAX_FIELDS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [12:8] field_number, [13] is_content, [14] field_closed,
    // [15] sentence_valid, [20:16] field_count, [28:21] running_checksum,
    // [29] too_long, [31:30] zero
    output logic [nsp_pkg::OUT_W-1:0] m_axis_tdata
);

    nsp_pkg::state_t  st_reg;
    nsp_pkg::state_t  st_next;
    nsp_pkg::result_t res_next;
    nsp_pkg::result_t res_reg;
    logic             out_valid_reg;
    logic             accept;

    // Accept a word whenever the output register is empty or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    nsp_update #(
        .MAX_LEN    (MAX_LEN),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_update (
        .in_byte (s_axis_tdata),
        .cur     (st_reg),
        .nxt     (st_next),
        .res     (res_next)
    );

    // Advance scanner state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

    // Hold the result valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;

    // A dollar opens field zero with nothing closed
    a_dollar_opens: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tdata == nsp_pkg::CH_DOLLAR |=>
            m_axis_tvalid && m_axis_tdata[12:8] == 5'd0 && m_axis_tdata[20:16] == 5'd0
            && st_reg.field_counter == nsp_pkg::FC_W'(1))
        else $error("dollar did not restart the sentence");

    // Field counter never passes its ceiling
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.field_counter <= nsp_pkg::FC_W'(MAX_FIELDS))
        else $error("field counter above ceiling");

    // Character count never passes the store length
    a_cc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.char_count <= nsp_pkg::CC_W'(MAX_LEN))
        else $error("character count above store length");

    // A star restarts the received checksum
    a_star_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tdata == nsp_pkg::CH_STAR |=>
            st_reg.after_star && st_reg.received_sum == 8'd0 && !st_reg.received_overflow)
        else $error("star did not restart received checksum");

endmodule

// ----- rtl/nsp_update.sv -----
// Next-state and result logic for one received character of the parser.
// Depends on nsp_pkg for the state and result types and character codes.
module nsp_update #(
    parameter int unsigned MAX_LEN    = 128,
    parameter int unsigned MAX_FIELDS = 32
) (
    input  logic [7:0]       in_byte,
    input  nsp_pkg::state_t  cur,
    output nsp_pkg::state_t  nxt,
    output nsp_pkg::result_t res
);

    localparam logic [nsp_pkg::FC_W-1:0] MaxFields = nsp_pkg::FC_W'(MAX_FIELDS);
    localparam logic [nsp_pkg::CC_W-1:0] MaxLen    = nsp_pkg::CC_W'(MAX_LEN);

    logic            line_end;
    logic            match;
    logic            fc_room;
    nsp_pkg::hex_t   hx;

    assign line_end = (in_byte == nsp_pkg::CH_CR) || (in_byte == nsp_pkg::CH_LF);
    assign fc_room  = (cur.field_counter < MaxFields);
    assign hx       = nsp_pkg::hex_decode(in_byte);
    assign match    = cur.after_star ? (!cur.received_overflow &&
                                        cur.received_sum == cur.xor_sum)
                                     : (cur.xor_sum == 8'd0);

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.out_byte     = in_byte;
        res.field_number = nsp_pkg::fields_less_one(cur.field_counter);

        // Classify the character and update fields and checksum
        priority if (in_byte == nsp_pkg::CH_DOLLAR)
        begin
            nxt = '0;
            nxt.field_counter = nsp_pkg::FC_W'(1);
            res.field_number  = 5'd0;
        end
        else if (in_byte == nsp_pkg::CH_COMMA)
        begin
            if (!cur.after_star)
            begin
                nxt.xor_sum = cur.xor_sum ^ in_byte;
            end
            if (fc_room)
            begin
                nxt.field_counter = cur.field_counter + nsp_pkg::FC_W'(1);
            end
            res.field_closed = 1'b1;
        end
        else if (line_end)
        begin
            nxt.valid_flag = match && !cur.valid_flag;
            if (nxt.valid_flag)
            begin
                if (fc_room)
                begin
                    nxt.field_counter = cur.field_counter + nsp_pkg::FC_W'(1);
                end
                res.field_closed = 1'b1;
            end
        end
        else if (in_byte == nsp_pkg::CH_STAR)
        begin
            if (fc_room)
            begin
                nxt.field_counter = cur.field_counter + nsp_pkg::FC_W'(1);
            end
            res.field_closed = 1'b1;
        end
        else
        begin
            res.is_content = 1'b1;
            if (!cur.after_star)
            begin
                nxt.xor_sum = cur.xor_sum ^ in_byte;
            end
        end

        // Store the character and gather received checksum digits
        if (!line_end && nxt.char_count < MaxLen)
        begin
            nxt.char_count = nxt.char_count + nsp_pkg::CC_W'(1);
            if (in_byte == nsp_pkg::CH_STAR)
            begin
                nxt.after_star        = 1'b1;
                nxt.received_sum      = 8'd0;
                nxt.received_overflow = 1'b0;
                nxt.hex_ended         = 1'b0;
            end
            else if (nxt.after_star && !nxt.hex_ended)
            begin
                if (!hx.is_hex)
                begin
                    nxt.hex_ended = 1'b1;
                end
                else
                begin
                    if (nxt.received_sum >= 8'd16)
                    begin
                        nxt.received_overflow = 1'b1;
                    end
                    nxt.received_sum = {nxt.received_sum[3:0], hx.value};
                end
            end
        end
        else if (!line_end && in_byte == nsp_pkg::CH_STAR)
        begin
            // A star past the store still restarts the digit run
            nxt.after_star        = 1'b1;
            nxt.received_sum      = 8'd0;
            nxt.received_overflow = 1'b0;
            nxt.hex_ended         = 1'b0;
        end

        res.sentence_valid   = nxt.valid_flag;
        res.field_count      = nsp_pkg::fields_less_one(nxt.field_counter);
        res.running_checksum = nxt.xor_sum;
        res.too_long         = (nxt.char_count >= MaxLen);
    end

endmodule
